FILE: design/vmvmm_pkg.sv
// Shared widths, command and status types for the vector statistics block.
package vmvmm_pkg;

  // Input sample width and the longest run that is accumulated.
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_LENGTH  = 4096;

  // Accumulator widths follow from the sample width and the run length.
  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int ABS_W  = SUM_W - 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W - 1;
  localparam int HALF_W = SQ_W / 2;

  // Numerator n*sumsq - sum^2 and the divisor n^2.
  localparam int NUM_W = CNT_W + SQ_W;
  localparam int N2_W  = 2 * CNT_W;

  // Eight fraction bits on mean, variance and standard deviation.
  localparam int FRAC_W = 8;
  localparam int DVD_W  = NUM_W + FRAC_W;

  // Result field widths.
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 39;
  localparam int SD_W   = 24;

  // Shared iteration counter for the divide and square root passes.
  localparam int STEP_W = $clog2(DVD_W);

  typedef struct packed {
    logic acc;
    logic mul_a;
    logic mul_b;
    logic num_ld;
    logic div_step;
    logic sqrt_ld;
    logic sqrt_step;
    logic out_ld;
  } vmvmm_cmd_t;

  typedef struct packed {
    logic step_last;
  } vmvmm_sts_t;

endpackage

FILE: design/vector_mean_var_min_max.sv
// Vector statistics top level. After the last sample of a vector the controller runs the
// products, the mean and variance divide steps, the square root steps and the result load,
// and then offers the result transfer.
// Throughput: one sample per cycle within a vector; the input is held off while a result is
// computed and while a finished result waits behind one not yet taken. Reset clears the accumulators
// and the controller; the output holds no valid result after reset.
module vector_mean_var_min_max (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Sample stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // [15:0] sample
  input  logic         s_axis_tlast,  // is_last
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] mean_q8, [62:24] variance_q8, [86:63] stddev_q8, [102:87] minimum,
  // [118:103] maximum, [131:119] sample_count, [132] length_overflow,
  // [135:133] zero.
  output logic [135:0] m_axis_tdata
);
  import vmvmm_pkg::*;

  vmvmm_cmd_t cmd;
  vmvmm_sts_t sts;

  logic [MEAN_W-1:0]      mean_q8;
  logic [VAR_W-1:0]       variance_q8;
  logic [SD_W-1:0]        stddev_q8;
  logic [SAMPLE_BITS-1:0] minimum;
  logic [SAMPLE_BITS-1:0] maximum;
  logic [CNT_W-1:0]       sample_count;
  logic                   length_overflow;

  // The controller steps through accumulation, the wide products, the long
  // divisions for mean and variance and the square root, then loads the
  // result register. A result may wait in that register while the next
  // vector is being accumulated; it is only overwritten once taken.
  vmvmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath keeps count, sum, sum of squares, minimum and maximum, and
  // works out variance as (n*sumsq - sum^2)/n^2 by a bit-serial division.
  vmvmm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .sample_i          (s_axis_tdata[SAMPLE_BITS-1:0]),
    .mean_q8_o         (mean_q8),
    .variance_q8_o     (variance_q8),
    .stddev_q8_o       (stddev_q8),
    .minimum_o         (minimum),
    .maximum_o         (maximum),
    .sample_count_o    (sample_count),
    .length_overflow_o (length_overflow)
  );

  // Fields are packed from the lowest bit up, with zero fill to a whole byte.
  assign m_axis_tdata = {3'b000, length_overflow, sample_count, maximum, minimum,
                         stddev_q8, variance_q8, mean_q8};

endmodule

FILE: design/vmvmm_dp.sv
// Datapath: accumulators, product registers, two long dividers and a square root.
module vmvmm_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vmvmm_pkg::vmvmm_cmd_t                  cmd_i,
  output vmvmm_pkg::vmvmm_sts_t                  sts_o,
  input  logic        [vmvmm_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic        [vmvmm_pkg::MEAN_W-1:0]    mean_q8_o,
  output logic        [vmvmm_pkg::VAR_W-1:0]     variance_q8_o,
  output logic        [vmvmm_pkg::SD_W-1:0]      stddev_q8_o,
  output logic        [vmvmm_pkg::SAMPLE_BITS-1:0] minimum_o,
  output logic        [vmvmm_pkg::SAMPLE_BITS-1:0] maximum_o,
  output logic        [vmvmm_pkg::CNT_W-1:0]     sample_count_o,
  output logic                                   length_overflow_o
);
  import vmvmm_pkg::*;

  localparam int SRM_W = SD_W + 2;

  // Accumulators.
  logic        [CNT_W-1:0]       count_q, count_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic        [SQ_W-1:0]        sq_q, sq_d;
  logic                          ovf_q, ovf_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;

  // Products.
  logic [CNT_W+HALF_W-1:0]        prod_lo_q;
  logic [CNT_W+SQ_W-HALF_W-1:0]   prod_hi_q;
  logic [ABS_W-1:0]               abs_q;
  logic [2*ABS_W-1:0]             sum2_q;
  logic [N2_W-1:0]                n2_q;

  // Dividers and square root.
  logic [DVD_W-1:0]   vdvd_q, mdvd_q;
  logic [N2_W-1:0]    vrem_q;
  logic [CNT_W-1:0]   mrem_q;
  logic [VAR_W-1:0]   vquo_q;
  logic [MEAN_W-1:0]  mquo_q;
  logic [2*SD_W-1:0]  rad_q;
  logic [SRM_W-1:0]   srem_q;
  logic [SD_W-1:0]    root_q;
  logic [STEP_W-1:0]  step_q;

  // Result register.
  logic [MEAN_W-1:0]       mean_out_q;
  logic [VAR_W-1:0]        var_out_q;
  logic [SD_W-1:0]         sd_out_q;
  logic [SAMPLE_BITS-1:0]  min_out_q, max_out_q;
  logic [CNT_W-1:0]        cnt_out_q;
  logic                    ovf_out_q;

  logic signed [SAMPLE_BITS-1:0] s;
  logic [2*SAMPLE_BITS-1:0]      s_sq;
  logic [SUM_W-1:0]              sum_neg;
  logic [NUM_W-1:0]              num;
  logic [N2_W:0]                 vrem_ext, vrem_sub;
  logic                          vbit;
  logic [CNT_W:0]                mrem_ext, mrem_sub;
  logic                          mbit;
  logic [SRM_W+1:0]              srem_ext, srem_sub, trial;
  logic                          sbit;

  assign s    = $signed(sample_i);
  assign s_sq = s * s;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    ovf_d   = ovf_q;
    min_d   = min_q;
    max_d   = max_q;
    if (cmd_i.acc) begin
      if (count_q == CNT_W'(MAX_LENGTH)) begin
        ovf_d = 1'b1;
      end else begin
        if (count_q == '0) begin
          min_d = s;
          max_d = s;
        end else begin
          if (s < min_q) min_d = s;
          if (s > max_q) max_d = s;
        end
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_q + {{(SUM_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
        sq_d    = sq_q + SQ_W'(s_sq);
      end
    end else if (cmd_i.out_ld) begin
      count_d = '0;
      sum_d   = '0;
      sq_d    = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      ovf_q   <= 1'b0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      ovf_q   <= ovf_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  assign sum_neg = -sum_q;
  assign num     = NUM_W'({prod_hi_q, {HALF_W{1'b0}}}) + NUM_W'(prod_lo_q) - NUM_W'(sum2_q);

  // One restoring division step for the variance and for the mean.
  assign vrem_ext = {vrem_q, vdvd_q[DVD_W-1]};
  assign vbit     = (vrem_ext >= {1'b0, n2_q});
  assign vrem_sub = vrem_ext - {1'b0, n2_q};
  assign mrem_ext = {mrem_q, mdvd_q[DVD_W-1]};
  assign mbit     = (mrem_ext >= {1'b0, count_q});
  assign mrem_sub = mrem_ext - {1'b0, count_q};

  // One digit of the square root: two radicand bits in, one root bit out.
  assign srem_ext = {srem_q, rad_q[2*SD_W-1 -: 2]};
  assign trial    = (SRM_W+2)'({root_q, 2'b01});
  assign sbit     = (srem_ext >= trial);
  assign srem_sub = srem_ext - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.num_ld) begin
      step_q <= STEP_W'(DVD_W - 1);
    end else if (cmd_i.sqrt_ld) begin
      step_q <= STEP_W'(SD_W - 1);
    end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  assign sts_o.step_last = (step_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      prod_lo_q <= count_q * sq_q[HALF_W-1:0];
      abs_q     <= sum_q[SUM_W-1] ? sum_neg[ABS_W-1:0] : sum_q[ABS_W-1:0];
      n2_q      <= count_q * count_q;
    end
    if (cmd_i.mul_b) begin
      prod_hi_q <= count_q * sq_q[SQ_W-1:HALF_W];
      sum2_q    <= abs_q * abs_q;
    end
    if (cmd_i.num_ld) begin
      vdvd_q <= {num, {FRAC_W{1'b0}}};
      mdvd_q <= DVD_W'({abs_q, {FRAC_W{1'b0}}});
      vrem_q <= '0;
      mrem_q <= '0;
      vquo_q <= '0;
      mquo_q <= '0;
    end else if (cmd_i.div_step) begin
      vdvd_q <= {vdvd_q[DVD_W-2:0], 1'b0};
      mdvd_q <= {mdvd_q[DVD_W-2:0], 1'b0};
      vrem_q <= vbit ? vrem_sub[N2_W-1:0] : vrem_ext[N2_W-1:0];
      mrem_q <= mbit ? mrem_sub[CNT_W-1:0] : mrem_ext[CNT_W-1:0];
      vquo_q <= {vquo_q[VAR_W-2:0], vbit};
      mquo_q <= {mquo_q[MEAN_W-2:0], mbit};
    end
    if (cmd_i.sqrt_ld) begin
      rad_q  <= (2*SD_W)'({vquo_q, {FRAC_W{1'b0}}});
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[2*SD_W-3:0], 2'b00};
      srem_q <= sbit ? srem_sub[SRM_W-1:0] : srem_ext[SRM_W-1:0];
      root_q <= {root_q[SD_W-2:0], sbit};
    end
    if (cmd_i.out_ld) begin
      mean_out_q <= sum_q[SUM_W-1] ? -mquo_q : mquo_q;
      var_out_q  <= vquo_q;
      sd_out_q   <= root_q;
      min_out_q  <= min_q;
      max_out_q  <= max_q;
      cnt_out_q  <= count_q;
      ovf_out_q  <= ovf_q;
    end
  end

  assign mean_q8_o         = mean_out_q;
  assign variance_q8_o     = var_out_q;
  assign stddev_q8_o       = sd_out_q;
  assign minimum_o         = min_out_q;
  assign maximum_o         = max_out_q;
  assign sample_count_o    = cnt_out_q;
  assign length_overflow_o = ovf_out_q;

endmodule

FILE: design/vmvmm_ctrl.sv
// Controller: sequences accumulation, products, division, square root and output.
module vmvmm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vmvmm_pkg::vmvmm_cmd_t cmd_o,
  input  vmvmm_pkg::vmvmm_sts_t sts_i
);
  import vmvmm_pkg::*;

  typedef enum logic [7:0] {
    ST_ACC   = 8'b0000_0001,
    ST_MUL_A = 8'b0000_0010,
    ST_MUL_B = 8'b0000_0100,
    ST_NUM   = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_SQL   = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num_ld = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) state_d = ST_SQL;
      end
      ST_SQL: begin
        cmd_o.sqrt_ld = 1'b1;
        state_d       = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.step_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_ACC);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the streaming vector mean, variance and extremes block.
`timescale 1ns / 1ps

module testbench;
  import vmvmm_pkg::*;

  // The run is stopped as failed if it is still going after this many cycles.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Cycles allowed after the last result, a little over the result latency.
  localparam int DRAIN_CYCLES = 150;
  // Length of the single long hold-off on the result side.
  localparam int HOLD_OFF_CYCLES = 400;
  // Samples in the random part, and the final stretch of it without idling.
  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_ITEMS = 200;

  // One result transfer, laid out as on the result bus (first member at the top).
  typedef struct packed {
    logic [2:0]                    pad;
    logic                          length_overflow;
    logic [CNT_W-1:0]              sample_count;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic [SD_W-1:0]               stddev_q8;
    logic [VAR_W-1:0]              variance_q8;
    logic signed [MEAN_W-1:0]      mean_q8;
  } vector_stats_t;

  // How the samples of a random vector are chosen.
  typedef enum int {
    STYLE_ANY,
    STYLE_EXTREME,
    STYLE_CLUSTER,
    STYLE_FLAT
  } sample_style_e;

  // Running statistics of the current vector and the results still owed.
  class stats_scoreboard;
    int unsigned                   run_len;
    longint                        run_sum;
    longint unsigned               run_sumsq;
    logic signed [SAMPLE_BITS-1:0] run_min;
    logic signed [SAMPLE_BITS-1:0] run_max;
    bit                            run_overflow;
    vector_stats_t                 owed[$];
    int                            errors;

    function new();
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      run_len = 0;
      run_sum = 0;
      run_sumsq = 0;
      run_min = '0;
      run_max = '0;
      run_overflow = 0;
    endfunction

    // Largest integer whose square does not exceed x, built bit by bit.
    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    // Called for every accepted sample; the last of a vector owes one result.
    function void note_sample(logic signed [SAMPLE_BITS-1:0] smp, bit last);
      vector_stats_t   res;
      longint unsigned n;
      longint unsigned n2;
      longint unsigned mag;
      longint unsigned num;
      longint unsigned quo;
      longint unsigned rem;
      longint unsigned var_q8;
      longint unsigned sd_q8;
      longint          mean;
      // A full vector swallows further samples, the last one included.
      if (run_len >= MAX_LENGTH) begin
        run_overflow = 1;
      end else begin
        if (run_len == 0) begin
          run_min = smp;
          run_max = smp;
        end else begin
          if (smp < run_min) run_min = smp;
          if (smp > run_max) run_max = smp;
        end
        run_len++;
        run_sum += smp;
        run_sumsq += longint'(smp) * longint'(smp);
      end
      if (!last) return;
      n = run_len;
      n2 = n * n;
      mag = (run_sum < 0) ? -run_sum : run_sum;
      num = n * run_sumsq - mag * mag;
      quo = num / n2;
      rem = num % n2;
      var_q8 = quo * 256 + (rem * 256) / n2;
      sd_q8 = floor_sqrt(var_q8 * 256);
      mean = (run_sum * 256) / longint'(n);
      res = '0;
      res.mean_q8 = mean[MEAN_W-1:0];
      res.variance_q8 = var_q8[VAR_W-1:0];
      res.stddev_q8 = sd_q8[SD_W-1:0];
      res.minimum = run_min;
      res.maximum = run_max;
      res.sample_count = n[CNT_W-1:0];
      res.length_overflow = run_overflow;
      owed.push_back(res);
      clear_run();
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_result(vector_stats_t got);
      vector_stats_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("mean_q8", longint'(want.mean_q8), longint'(got.mean_q8));
      compare_field("variance_q8", longint'(want.variance_q8), longint'(got.variance_q8));
      compare_field("stddev_q8", longint'(want.stddev_q8), longint'(got.stddev_q8));
      compare_field("minimum", longint'(want.minimum), longint'(got.minimum));
      compare_field("maximum", longint'(want.maximum), longint'(got.maximum));
      compare_field("sample_count", longint'(want.sample_count),
                    longint'(got.sample_count));
      compare_field("length_overflow", longint'(want.length_overflow),
                    longint'(got.length_overflow));
      compare_field("padding", longint'(want.pad), longint'(got.pad));
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  stats_scoreboard stats = new;

  // Idling switches for each side and the request for the long hold-off.
  bit tx_gaps = 1;
  bit rx_gaps = 1;
  bit rx_hold_req = 0;

  int unsigned cycle_count = 0;

  vector_mean_var_min_max dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every result transfer is checked at the clock edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) stats.check_result(m_axis_tdata);
  end

  // Result side: random bursts of back-pressure, plus the one long hold-off.
  initial begin
    int gap_left;
    int hold_left;
    bit hold_taken;
    gap_left = 0;
    hold_left = 0;
    hold_taken = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req && !hold_taken) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_taken = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 19) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offers one sample, waits for its transfer and records it. Entered and left
  // at a falling edge, so valid stays high between back-to-back samples.
  task automatic push(input logic signed [15:0] smp, input bit last);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = smp;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    stats.note_sample(smp, last);
    @(negedge clk_i);
  endtask

  task automatic send_list(input int vals[$]);
    foreach (vals[i]) push(16'(vals[i]), i == vals.size() - 1);
  endtask

  // One random vector whose samples follow a randomly chosen style.
  task automatic random_vector(input int len);
    sample_style_e     style;
    logic signed [15:0] base;
    logic signed [15:0] smp;
    style = sample_style_e'($urandom_range(0, 3));
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        STYLE_ANY: smp = 16'($urandom);
        STYLE_EXTREME: begin
          case ($urandom_range(0, 3))
            0: smp = -16'sd32768;
            1: smp = 16'sd32767;
            2: smp = -16'sd1;
            default: smp = 16'sd0;
          endcase
        end
        STYLE_CLUSTER: smp = base + 16'($urandom_range(0, 64)) - 16'sd32;
        default: smp = base;
      endcase
      push(smp, i == len - 1);
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 12);
    if (r < 19) return $urandom_range(13, 64);
    return $urandom_range(65, 200);
  endfunction

  task automatic wait_for_results();
    while (stats.owed.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int  rand_items;
    int  len;
    bit  held;
    bit  paused;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    rand_items = 0;
    held = 0;
    paused = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed vectors: single extreme samples, a full-swing pair, a mean that
    // must truncate towards zero, zero variance and scattered extremes.
    send_list('{32767});
    send_list('{-32768});
    send_list('{0});
    send_list('{-32768, 32767});
    send_list('{-1, 0, 1});
    send_list('{-1, -1, 0});
    send_list('{5, 5, 5, 5});
    send_list('{7, -3, 100, -32768, 32767, 1, 2});

    // Random vectors, mostly short, with the idling of each side switched on
    // and off in stretches and turned off for the final part.
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_gaps = 0;
        rx_gaps = 0;
      end else begin
        if ($urandom_range(0, 7) == 0) tx_gaps = !tx_gaps;
        if ($urandom_range(0, 7) == 0) rx_gaps = !rx_gaps;
      end
      if (!held && rand_items >= 500) begin
        // The result side stops while short vectors keep coming, so the block
        // has to hold off its input.
        held = 1;
        rx_hold_req = 1;
        for (int v = 0; v < 10; v++) begin
          len = $urandom_range(1, 3);
          random_vector(len);
          rand_items += len;
        end
      end
      if (!paused && rand_items >= 1000) begin
        paused = 1;
        s_axis_tvalid = 1'b0;
        wait_for_results();
      end
      len = pick_length();
      random_vector(len);
      rand_items += len;
    end

    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (stats.errors == 0 && stats.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/vmvmm_pkg.sv
design/vmvmm_dp.sv
design/vmvmm_ctrl.sv
design/vector_mean_var_min_max.sv
sim/testbench.sv
